/* rtl/core/spq_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_mem, spq_ctrl and sorted_priority_queue.
package spq_pkg;

	localparam int SPQ_DEPTH    = 8;
	localparam int SPQ_ADDR_W   = 6;   // enough for the largest supported depth
	localparam int SPQ_VALUE_W  = 32;
	localparam int SPQ_PRIO_W   = 8;
	localparam int SPQ_S_DATA_W = 40;
	localparam int SPQ_M_DATA_W = 48;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		REQ_ENQ = 1'b0,
		REQ_DEQ = 1'b1
	} req_t;

	typedef struct packed {
		logic [SPQ_PRIO_W-1:0]  prio;
		logic [SPQ_VALUE_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic                  re;
		logic [SPQ_ADDR_W-1:0] raddr;
		logic                  we;
		logic [SPQ_ADDR_W-1:0] waddr;
		entry_t                wdata;
	} mem_req_t;

endpackage

/* rtl/core/spq_mem.sv */
`timescale 1ns / 1ps
// Entry storage: one write port, one read port with a registered read.
// Depends on spq_pkg for the entry and request types.
module spq_mem #(
	parameter int DEPTH = 8
) (
	input  logic              clk,
	input  spq_pkg::mem_req_t req,
	output spq_pkg::entry_t   rd_data
);
	import spq_pkg::*;

	localparam int AW = $clog2(DEPTH);

	entry_t mem_q [DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr[AW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem_q[req.raddr[AW-1:0]];
		end
	end

	assign rd_data = rd_q;

endmodule

/* rtl/core/spq_ctrl.sv */
`timescale 1ns / 1ps
// Request sequencer: circular head pointer, insertion walk, output register.
// Depends on spq_pkg; drives the spq_mem request port.
module spq_ctrl #(
	parameter int DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  spq_pkg::entry_t   s_entry,
	input  logic              s_req,
	output logic              m_tvalid,
	input  logic              m_tready,
	output spq_pkg::status_t  m_status,
	output spq_pkg::entry_t   m_entry,
	output logic              m_empty,
	output logic              m_full,
	output spq_pkg::mem_req_t mreq,
	input  spq_pkg::entry_t   rd_data
);
	import spq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_PLACE,
		S_DEQ,
		S_RESP
	} state_t;

	state_t        state_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] pos_q;
	logic [CW-1:0] lpos_q;
	entry_t        new_q;
	status_t       res_status_q;
	entry_t        res_entry_q;
	logic          m_valid_q;
	status_t       out_status_q;
	entry_t        out_entry_q;
	logic          out_empty_q;
	logic          out_full_q;

	logic [AW-1:0] tail;
	logic          is_full_now;
	logic          is_empty_now;
	logic          shift_up;
	logic          accept;

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == '0) begin
			r = AW'(DEPTH - 1);
		end else begin
			r = p - AW'(1);
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + AW'(1);
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [CW-1:0] n);
		logic [AW:0] s;
		s = {1'b0, p} + (AW+1)'(n);
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign tail         = ptr_add(head_q, count_q);
	assign is_full_now  = (count_q == CW'(DEPTH));
	assign is_empty_now = (count_q == '0);
	assign shift_up     = (rd_data.prio > new_q.prio);
	assign s_tready     = (state_q == S_IDLE);
	assign accept       = s_tvalid && s_tready;

	// Memory port: one read and one write per cycle; the walk never reads
	// the slot it writes, since it stays below the held entry count.
	always_comb begin
		mreq = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (s_req == REQ_ENQ) begin
						if (!is_full_now) begin
							if (is_empty_now) begin
								mreq.we    = 1'b1;
								mreq.waddr = SPQ_ADDR_W'(tail);
								mreq.wdata = s_entry;
							end else begin
								mreq.re    = 1'b1;
								mreq.raddr = SPQ_ADDR_W'(ptr_dec(tail));
							end
						end
					end else if (!is_empty_now) begin
						mreq.re    = 1'b1;
						mreq.raddr = SPQ_ADDR_W'(head_q);
					end
				end
			end
			S_WALK: begin
				mreq.we    = 1'b1;
				mreq.waddr = SPQ_ADDR_W'(pos_q);
				if (shift_up) begin
					mreq.wdata = rd_data;
					if (lpos_q > CW'(1)) begin
						mreq.re    = 1'b1;
						mreq.raddr = SPQ_ADDR_W'(ptr_dec(ptr_dec(pos_q)));
					end
				end else begin
					mreq.wdata = new_q;
				end
			end
			S_PLACE: begin
				mreq.we    = 1'b1;
				mreq.waddr = SPQ_ADDR_W'(pos_q);
				mreq.wdata = new_q;
			end
			S_DEQ, S_RESP: begin
				mreq = '0;
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			pos_q     <= '0;
			lpos_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// drop the presented item once taken, unless a new one is loaded now
			if (m_valid_q && m_tready && state_q != S_RESP) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_entry_q <= '0;
						res_status_q <= ST_OK;
						if (s_req == REQ_ENQ) begin
							if (is_full_now) begin
								res_status_q <= ST_FULL;
								state_q      <= S_RESP;
							end else begin
								new_q   <= s_entry;
								count_q <= count_q + CW'(1);
								pos_q   <= tail;
								lpos_q  <= count_q;
								state_q <= is_empty_now ? S_RESP : S_WALK;
							end
						end else begin
							if (is_empty_now) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_RESP;
							end else begin
								head_q  <= ptr_inc(head_q);
								count_q <= count_q - CW'(1);
								state_q <= S_DEQ;
							end
						end
					end
				end
				S_WALK: begin
					if (shift_up) begin
						pos_q  <= ptr_dec(pos_q);
						lpos_q <= lpos_q - CW'(1);
						if (lpos_q == CW'(1)) begin
							state_q <= S_PLACE;
						end
					end else begin
						state_q <= S_RESP;
					end
				end
				S_PLACE: begin
					state_q <= S_RESP;
				end
				S_DEQ: begin
					res_entry_q <= rd_data;
					state_q     <= S_RESP;
				end
				S_RESP: begin
					// hold until the output register is free
					if (!m_valid_q || m_tready) begin
						m_valid_q    <= 1'b1;
						out_status_q <= res_status_q;
						out_entry_q  <= res_entry_q;
						out_empty_q  <= is_empty_now;
						out_full_q   <= is_full_now;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_status = out_status_q;
	assign m_entry  = out_entry_q;
	assign m_empty  = out_empty_q;
	assign m_full   = out_full_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (lpos_q != '0) && (lpos_q < count_q))
		else $error("insertion walk outside held entries");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_status_q == ST_FULL) |-> out_full_q)
		else $error("full reject without full flag");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_status_q == ST_EMPTY) |-> out_empty_q)
		else $error("empty reject without empty flag");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("item taken while another is in flight");

endmodule

/* rtl/core/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// Sorted priority queue of DEPTH entries, lowest priority number first.
// Input channel s_*: tuser carries the request kind (0 enqueue, 1 dequeue),
// tdata the value and priority. Every item yields one result item on m_*:
// tuser holds the status (ok, rejected full, dequeue on empty), tdata the
// removed value and priority (zero unless a dequeue succeeded) and the empty
// and full flags as they stand after the request.
// Entries sit in one memory with a registered read, used as a ring with a
// moving head; equal priorities keep arrival order.
// Rejected requests and enqueues into an empty queue go straight to the result
// state; a dequeue first reads the head entry; other enqueues move each held
// entry of higher priority number up one slot (one memory read and write per
// moved entry), then write the new entry. One item is in work at a time; the
// next is taken the cycle after the result is loaded into the output register.
// Reset empties the queue and clears the output valid; no clearing pass.
// A stalled receiver holds the result in the output register; the block still
// takes and works the next item, then waits to present it.
// Depends on spq_pkg, spq_mem and spq_ctrl.
module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [spq_pkg::SPQ_S_DATA_W-1:0] s_tdata,  // item_value[31:0], item_prio[39:32]
	input  logic [0:0]                       s_tuser,  // req_type[0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [spq_pkg::SPQ_M_DATA_W-1:0] m_tdata,  // out_value[31:0], out_prio[39:32],
	                                                   // is_empty[40], is_full[41], zero[47:42]
	output logic [1:0]                       m_tuser   // status[1:0]
);
	import spq_pkg::*;

	mem_req_t mreq;
	entry_t   rd_data;
	entry_t   s_entry;
	entry_t   m_entry;
	status_t  m_status;
	logic     m_empty;
	logic     m_full;

	assign s_entry.value = s_tdata[SPQ_VALUE_W-1:0];
	assign s_entry.prio  = s_tdata[SPQ_VALUE_W +: SPQ_PRIO_W];

	spq_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk     (clk),
		.req     (mreq),
		.rd_data (rd_data)
	);

	spq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_entry  (s_entry),
		.s_req    (s_tuser[0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_status (m_status),
		.m_entry  (m_entry),
		.m_empty  (m_empty),
		.m_full   (m_full),
		.mreq     (mreq),
		.rd_data  (rd_data)
	);

	assign m_tdata = {6'd0, m_full, m_empty, m_entry.prio, m_entry.value};
	assign m_tuser = m_status;

endmodule
